@@ rtl/core/pllacc_pkg.sv @@
// Shared types, constants and helpers for the point light lumel accumulator.
package pllacc_pkg;

    // Geometry and number formats
    localparam int MAP_DIM     = 256;
    localparam int COORD_WIDTH = 16;
    localparam int IDX_W       = 8;
    localparam int PROD_W      = COORD_WIDTH + IDX_W + 1;
    localparam int DIFF_W      = COORD_WIDTH + IDX_W + 4;
    localparam int MAG_W       = 16;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int D2_W        = SQ_W + 2;
    localparam int R2_W        = 32;
    localparam int REM_W       = R2_W + 1;
    localparam int Q_W         = 9;
    localparam int ADD_W       = 9;
    localparam int PACK_W      = 48;

    localparam logic [Q_W-1:0] INTENS_ONE_ONE = Q_W'(282);
    localparam logic [7:0]     BYTE_MAX       = 8'hFF;

    // Queue between classifier and shading pipeline
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_LIGHT_POS = 3'd0,
        REG_RADIUS_SQ = 3'd1,
        REG_COLOR     = 3'd2,
        REG_ORIGIN    = 3'd3,
        REG_U_STEP    = 3'd4,
        REG_V_STEP    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [PACK_W-1:0] light_pos;
        logic [R2_W-1:0]   radius_sq;
        logic [23:0]       color;
        logic [PACK_W-1:0] origin;
        logic [PACK_W-1:0] u_step;
        logic [PACK_W-1:0] v_step;
    } cfg_t;

    typedef struct packed {
        logic [7:0]      b0;
        logic [7:0]      b1;
        logic [7:0]      b2;
        logic            go;
        logic [R2_W-1:0] d2;
    } qent_t;

    // Pull one signed coordinate out of a packed triple; missing bits read zero
    function automatic logic signed [COORD_WIDTH-1:0] coord_of(
        input logic [PACK_W-1:0] packed_v,
        input int                axis
    );
        logic [PACK_W+3*COORD_WIDTH-1:0] ext;
        ext = {{(3*COORD_WIDTH){1'b0}}, packed_v};
        return ext[axis*COORD_WIDTH +: COORD_WIDTH];
    endfunction

endpackage

@@ rtl/core/pllacc_fifo.sv @@
// Short queue that decouples the classifier from the shading pipeline.
module pllacc_fifo
    import pllacc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  qent_t push_data,
    input  logic  pop,
    output qent_t head,
    output logic  full,
    output logic  empty
);

    qent_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_CW-1:0]  count_reg;
    logic [QUEUE_CW-1:0]  count_next;

    assign full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

endmodule

@@ rtl/core/pllacc_front.sv @@
// Classifier: lumel position, squared distance and inside-radius test.
module pllacc_front
    import pllacc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [IDX_W-1:0] lumel_col,
    input  logic [IDX_W-1:0] lumel_row,
    input  logic [7:0]       in_byte0,
    input  logic [7:0]       in_byte1,
    input  logic [7:0]       in_byte2,
    input  logic             q_full,
    output logic             q_push,
    output qent_t            q_data
);

    logic en;

    // Stage 1: products
    logic                     v1_reg;
    logic signed [PROD_W-1:0] pu_reg [3];
    logic signed [PROD_W-1:0] pv_reg [3];
    logic signed [PROD_W-1:0] pu_next [3];
    logic signed [PROD_W-1:0] pv_next [3];
    logic [7:0]               b0_1_reg, b1_1_reg, b2_1_reg;
    logic                     skip1_reg;
    logic                     skip1_next;

    // Stage 2: magnitudes
    logic                     v2_reg;
    logic [MAG_W-1:0]         m_reg [3];
    logic [MAG_W-1:0]         m_next [3];
    logic                     far2_reg, far2_next;
    logic [7:0]               b0_2_reg, b1_2_reg, b2_2_reg;
    logic                     skip2_reg;

    // Stage 3: squares
    logic                     v3_reg;
    logic [SQ_W-1:0]          sq_reg [3];
    logic                     far3_reg;
    logic [7:0]               b0_3_reg, b1_3_reg, b2_3_reg;
    logic                     skip3_reg;

    // Stage 4: radius test
    logic                     v4_reg;
    qent_t                    ent4_reg;
    qent_t                    ent4_next;
    logic [D2_W-1:0]          d2_sum;

    assign en       = !v4_reg || !q_full;
    assign in_stall = !en;
    assign q_push   = v4_reg && !q_full;
    assign q_data   = ent4_reg;

    // Form per-axis index products and the early skip
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            pu_next[a] = $signed({1'b0, lumel_col}) * coord_of(cfg.u_step, a);
            pv_next[a] = $signed({1'b0, lumel_row}) * coord_of(cfg.v_step, a);
        end
        skip1_next = (in_byte0 == BYTE_MAX && in_byte1 == BYTE_MAX && in_byte2 == BYTE_MAX)
                   || (32'(lumel_col) >= 32'(MAP_DIM)) || (32'(lumel_row) >= 32'(MAP_DIM));
    end

    // Sum position, subtract light, take magnitude
    always_comb
    begin
        logic signed [DIFF_W-1:0] d;
        logic [DIFF_W-1:0]        mag;
        far2_next = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            d = DIFF_W'(coord_of(cfg.origin, a)) + DIFF_W'(pu_reg[a]) + DIFF_W'(pv_reg[a])
              - DIFF_W'(coord_of(cfg.light_pos, a));
            mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
            m_next[a] = mag[MAG_W-1:0];
            if (mag[DIFF_W-1:MAG_W] != '0)
                far2_next = 1'b1;
        end
    end

    // Accumulate and compare against radius squared
    always_comb
    begin
        d2_sum = D2_W'(sq_reg[0]) + D2_W'(sq_reg[1]) + D2_W'(sq_reg[2]);
        ent4_next.b0 = b0_3_reg;
        ent4_next.b1 = b1_3_reg;
        ent4_next.b2 = b2_3_reg;
        ent4_next.go = !skip3_reg && !far3_reg && (d2_sum <= D2_W'(cfg.radius_sq));
        ent4_next.d2 = d2_sum[R2_W-1:0];
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                pu_reg[a] <= pu_next[a];
                pv_reg[a] <= pv_next[a];
                m_reg[a]  <= m_next[a];
                sq_reg[a] <= m_reg[a] * m_reg[a];
            end
            b0_1_reg  <= in_byte0;
            b1_1_reg  <= in_byte1;
            b2_1_reg  <= in_byte2;
            skip1_reg <= skip1_next;
            b0_2_reg  <= b0_1_reg;
            b1_2_reg  <= b1_1_reg;
            b2_2_reg  <= b2_1_reg;
            skip2_reg <= skip1_reg;
            far2_reg  <= far2_next;
            b0_3_reg  <= b0_2_reg;
            b1_3_reg  <= b1_2_reg;
            b2_3_reg  <= b2_2_reg;
            skip3_reg <= skip2_reg;
            far3_reg  <= far2_reg;
            ent4_reg  <= ent4_next;
        end
    end

endmodule

@@ rtl/core/pllacc_back.sv @@
// Shading pipeline: pipelined d2/r2 divider, color scale and saturating add.
module pllacc_back
    import pllacc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  qent_t      q_head,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte0,
    output logic [7:0] out_byte1,
    output logic [7:0] out_byte2,
    output logic       lit
);

    logic en;

    // Divider stages, one quotient bit each
    logic             dv_reg   [Q_W];
    logic [REM_W-1:0] rem_reg  [Q_W];
    logic [REM_W-1:0] rem_next [Q_W];
    logic [Q_W-1:0]   q_reg    [Q_W];
    logic [Q_W-1:0]   q_next   [Q_W];
    logic [7:0]       b0_reg [Q_W], b1_reg [Q_W], b2_reg [Q_W];
    logic             go_reg [Q_W];

    // Color scale stage
    logic             mv_reg;
    logic [ADD_W-1:0] add0_reg, add1_reg, add2_reg;
    logic [ADD_W-1:0] add0_next, add1_next, add2_next;
    logic [7:0]       mb0_reg, mb1_reg, mb2_reg;
    logic             mgo_reg;

    // Output register
    logic             ov_reg;
    logic [7:0]       ob0_reg, ob1_reg, ob2_reg;
    logic             olit_reg;

    assign en        = !ov_reg || !out_stall;
    assign q_pop     = en && !q_empty;
    assign out_valid = ov_reg;
    assign out_byte0 = ob0_reg;
    assign out_byte1 = ob1_reg;
    assign out_byte2 = ob2_reg;
    assign lit       = olit_reg;

    // Restoring division steps: remainder stays below a nonzero r2 while d2 is at most r2
    always_comb
    begin
        logic [REM_W-1:0] t;
        logic             ge;
        for (int k = 0; k < Q_W; k++)
        begin
            if (k == 0)
            begin
                t = REM_W'(q_head.d2);
                ge = (t >= REM_W'(cfg.radius_sq));
                q_next[k] = Q_W'(ge);
            end
            else
            begin
                t = {rem_reg[k-1][REM_W-2:0], 1'b0};
                ge = (t >= REM_W'(cfg.radius_sq));
                q_next[k] = {q_reg[k-1][Q_W-2:0], ge};
            end
            rem_next[k] = ge ? t - REM_W'(cfg.radius_sq) : t;
        end
    end

    // Scale light color by intensity; skipped lumels gain nothing
    always_comb
    begin
        logic [Q_W-1:0]       qf;
        logic [Q_W-1:0]       intens;
        logic [Q_W+7:0]       p0, p1, p2;
        qf     = (cfg.radius_sq == '0) ? '0 : q_reg[Q_W-1];
        intens = INTENS_ONE_ONE - qf;
        p0 = intens * cfg.color[15:8];
        p1 = intens * cfg.color[7:0];
        p2 = intens * cfg.color[23:16];
        add0_next = go_reg[Q_W-1] ? p0[Q_W+7:8] : '0;
        add1_next = go_reg[Q_W-1] ? p1[Q_W+7:8] : '0;
        add2_next = go_reg[Q_W-1] ? p2[Q_W+7:8] : '0;
    end

    function automatic logic [7:0] sat_add(input logic [7:0] b, input logic [ADD_W-1:0] a);
        logic [ADD_W:0] s;
        s = (ADD_W+1)'(b) + (ADD_W+1)'(a);
        return (s > (ADD_W+1)'(BYTE_MAX)) ? BYTE_MAX : s[7:0];
    endfunction

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < Q_W; k++)
                dv_reg[k] <= 1'b0;
            mv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            dv_reg[0] <= !q_empty;
            for (int k = 1; k < Q_W; k++)
                dv_reg[k] <= dv_reg[k-1];
            mv_reg <= dv_reg[Q_W-1];
            ov_reg <= mv_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < Q_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
            end
            b0_reg[0] <= q_head.b0;
            b1_reg[0] <= q_head.b1;
            b2_reg[0] <= q_head.b2;
            go_reg[0] <= q_head.go;
            for (int k = 1; k < Q_W; k++)
            begin
                b0_reg[k] <= b0_reg[k-1];
                b1_reg[k] <= b1_reg[k-1];
                b2_reg[k] <= b2_reg[k-1];
                go_reg[k] <= go_reg[k-1];
            end
            add0_reg <= add0_next;
            add1_reg <= add1_next;
            add2_reg <= add2_next;
            mb0_reg  <= b0_reg[Q_W-1];
            mb1_reg  <= b1_reg[Q_W-1];
            mb2_reg  <= b2_reg[Q_W-1];
            mgo_reg  <= go_reg[Q_W-1];
            ob0_reg  <= sat_add(mb0_reg, add0_reg);
            ob1_reg  <= sat_add(mb1_reg, add1_reg);
            ob2_reg  <= sat_add(mb2_reg, add2_reg);
            olit_reg <= mgo_reg;
        end
    end

endmodule

@@ rtl/core/point_light_lumel_accumulate.sv @@
// Classifier, queue and shading pipeline; the 9-stage pipelined divider sets its depth.
// Throughput: one lumel per cycle while out_stall is low.
// A stalled output fills the 4-entry queue before the input stalls.
// Reset (rst_n low, async) empties pipelines and queue; config registers go to 0,
// radius_squared to 1.
// Top level: configuration registers, classifier, queue and shading pipeline.
module point_light_lumel_accumulate
    import pllacc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [PACK_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [IDX_W-1:0]  lumel_col,
    input  logic [IDX_W-1:0]  lumel_row,
    input  logic [7:0]        in_byte0,
    input  logic [7:0]        in_byte1,
    input  logic [7:0]        in_byte2,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte0,
    output logic [7:0]        out_byte1,
    output logic [7:0]        out_byte2,
    output logic              lit
);

    cfg_t  cfg_reg;
    logic  q_push, q_pop, q_full, q_empty;
    qent_t q_data, q_head;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_pos <= '0;
            cfg_reg.radius_sq <= R2_W'(1);
            cfg_reg.color     <= '0;
            cfg_reg.origin    <= '0;
            cfg_reg.u_step    <= '0;
            cfg_reg.v_step    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_LIGHT_POS: cfg_reg.light_pos <= cfg_data;
                REG_RADIUS_SQ: cfg_reg.radius_sq <= cfg_data[R2_W-1:0];
                REG_COLOR:     cfg_reg.color     <= cfg_data[23:0];
                REG_ORIGIN:    cfg_reg.origin    <= cfg_data;
                REG_U_STEP:    cfg_reg.u_step    <= cfg_data;
                REG_V_STEP:    cfg_reg.v_step    <= cfg_data;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    pllacc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .lumel_col (lumel_col),
        .lumel_row (lumel_row),
        .in_byte0  (in_byte0),
        .in_byte1  (in_byte1),
        .in_byte2  (in_byte2),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    pllacc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    pllacc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte0 (out_byte0),
        .out_byte1 (out_byte1),
        .out_byte2 (out_byte2),
        .lit       (lit)
    );

endmodule
